FILE: design/khc_pkg.sv
package khc_pkg;

    localparam int TABLE_SIZE_DEF  = 10;
    localparam int KEY_COUNT_DEF   = 1024;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int KEY_W    = 10;
    localparam int HOUR_W   = 5;
    localparam int RRANK_W  = 4;
    localparam int SEL_W    = 6;
    localparam int RANK_W   = 6;   // holds 0..63, enough for a table size up to 63
    localparam int OCOUNT_W = 32;

    localparam logic KIND_COUNT = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic CFG_SKIP_NON_WEB = 1'b0;
    localparam logic CFG_HOUR_SELECT  = 1'b1;

    localparam logic [SEL_W-1:0] HOUR_ANY = 6'h3F;

    typedef struct packed {
        logic                kind;
        logic [KEY_W-1:0]    key;
        logic                is_web_content;
        logic [HOUR_W-1:0]   hour;
        logic [RRANK_W-1:0]  read_rank;
    } khc_req_t;

    typedef struct packed {
        logic                accepted;
        logic [OCOUNT_W-1:0] key_count;
        logic [RRANK_W-1:0]  key_rank;
        logic [KEY_W-1:0]    entry_key;
        logic [OCOUNT_W-1:0] entry_hits;
        logic                entry_valid;
    } khc_rsp_t;

    typedef struct packed {
        logic scan;
        logic apply;
        logic read;
    } khc_tbl_ctrl_t;

    typedef struct packed {
        logic              done;
        logic [RANK_W-1:0] rank;
    } khc_tbl_stat_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_COUNT,
        ST_TREAD,
        ST_WAIT,
        ST_DONE
    } khc_state_t;

    typedef enum logic [1:0] {
        TBL_IDLE,
        TBL_SCAN,
        TBL_UPDATE
    } khc_tbl_state_t;

endpackage

FILE: design/key_hit_counter_top_ten_unit.sv
// channel  | signals                          | direction | item
// req      | req_valid, req_stall, req        | in        | count or read request
// rsp      | rsp_valid, rsp_stall, rsp        | out       | one result per request
// cfg      | cfg_valid, cfg_ready, cfg_index, | in        | register write
//          | cfg_data                         |           |
//
// a count item goes from accept to result through counter fetch,
// increment and write-back, then one ranked entry per cycle in the table walk
// and then the shift; a read item reads the table entry at its rank.
// after reset the counter memory is cleared one entry a cycle, over all KEY_COUNT
// entries, with req_stall high; config writes are taken at any time.
// the next item is accepted as soon as its result is loaded, even if rsp is stalled.
module key_hit_counter_top_ten_unit #(
    parameter int TABLE_SIZE  = khc_pkg::TABLE_SIZE_DEF,
    parameter int KEY_COUNT   = khc_pkg::KEY_COUNT_DEF,
    parameter int COUNT_WIDTH = khc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  khc_pkg::khc_req_t           req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output khc_pkg::khc_rsp_t           rsp,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [khc_pkg::SEL_W-1:0]   cfg_data
);
    import khc_pkg::*;

    localparam int AW        = $clog2(KEY_COUNT);
    localparam int MOD_STEPS = KEY_W - 4;
    localparam logic [AW-1:0] CLEAR_LAST = AW'(KEY_COUNT - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    khc_state_t state_reg, state_next;

    logic [COUNT_WIDTH-1:0] mem [KEY_COUNT];
    logic [COUNT_WIDTH-1:0] rdata_reg;

    logic [AW-1:0]          clear_addr_reg;
    logic [AW-1:0]          key_addr_reg;
    logic [KEY_W-1:0]       key_reg;
    logic                   kind_reg;
    logic                   ok_reg;
    logic [RRANK_W-1:0]     read_rank_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic                   skip_reg;
    logic [SEL_W-1:0]       hour_sel_reg;
    khc_rsp_t               rsp_reg;
    logic                   rsp_valid_reg;

    logic                   accept;
    logic                   pass;
    logic [KEY_W-1:0]       key_mod;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic                   rsp_load;
    khc_rsp_t               rsp_new;

    khc_tbl_ctrl_t          tbl_ctrl;
    khc_tbl_stat_t          tbl_stat;
    logic [KEY_W-1:0]       tbl_entry_key;
    logic [COUNT_WIDTH-1:0] tbl_entry_hits;
    logic                   tbl_entry_valid;

    // key modulo store depth by restoring subtraction, one quotient bit a step
    function automatic logic [KEY_W-1:0] key_reduce(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] v;
        v = k;
        for (int b = MOD_STEPS - 1; b >= 0; b--)
        begin
            if (32'(v) >= (32'(KEY_COUNT) << b))
                v = v - KEY_W'(32'(KEY_COUNT) << b);
        end
        return v;
    endfunction

    assign accept  = req_valid && !req_stall;
    assign key_mod = key_reduce(req.key);
    assign pass    = !(skip_reg && !req.is_web_content)
                     && ((hour_sel_reg == HOUR_ANY) || (hour_sel_reg == {1'b0, req.hour}));

    assign count_next = (ok_reg && (rdata_reg != COUNT_MAX)) ? rdata_reg + 1'b1 : rdata_reg;

    assign mem_we    = (state_reg == ST_CLEAR) || ((state_reg == ST_COUNT) && ok_reg);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clear_addr_reg : key_addr_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : count_next;

    assign tbl_ctrl.scan  = (state_reg == ST_COUNT);
    assign tbl_ctrl.apply = ok_reg;
    assign tbl_ctrl.read  = (state_reg == ST_TREAD);

    assign rsp_load = (state_reg == ST_DONE) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        rsp_new = '0;
        if (kind_reg == KIND_READ)
        begin
            rsp_new.entry_key   = tbl_entry_key;
            rsp_new.entry_hits  = OCOUNT_W'(tbl_entry_hits);
            rsp_new.entry_valid = tbl_entry_valid;
        end
        else
        begin
            rsp_new.accepted  = ok_reg;
            rsp_new.key_count = OCOUNT_W'(count_reg);
            rsp_new.key_rank  = tbl_stat.rank[RRANK_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_stall  = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_addr_reg == CLEAR_LAST)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                    state_next = (req.kind == KIND_READ) ? ST_TREAD : ST_FETCH;
            end
            ST_FETCH:
            begin
                state_next = ST_COUNT;
            end
            ST_COUNT:
            begin
                state_next = ST_WAIT;
            end
            ST_TREAD:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (tbl_stat.done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[key_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
            skip_reg       <= 1'b0;
            hour_sel_reg   <= HOUR_ANY;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_CLEAR)
                clear_addr_reg <= clear_addr_reg + 1'b1;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_SKIP_NON_WEB: skip_reg     <= cfg_data[0];
                    CFG_HOUR_SELECT:  hour_sel_reg <= cfg_data;
                endcase
            end
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg      <= req.kind;
            key_reg       <= key_mod;
            key_addr_reg  <= AW'(key_mod);
            ok_reg        <= pass && (req.kind == KIND_COUNT);
            read_rank_reg <= req.read_rank;
        end
        if (state_reg == ST_COUNT)
            count_reg <= count_next;
        if (rsp_load)
            rsp_reg <= rsp_new;
    end

    khc_rank_table #(
        .TABLE_SIZE  (TABLE_SIZE),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (tbl_ctrl),
        .key         (key_reg),
        .hits        (count_next),
        .read_rank   (read_rank_reg),
        .stat        (tbl_stat),
        .entry_key   (tbl_entry_key),
        .entry_hits  (tbl_entry_hits),
        .entry_valid (tbl_entry_valid)
    );

    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: design/khc_rank_table.sv
module khc_rank_table #(
    parameter int TABLE_SIZE  = khc_pkg::TABLE_SIZE_DEF,
    parameter int COUNT_WIDTH = khc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  khc_pkg::khc_tbl_ctrl_t        ctrl,
    input  logic [khc_pkg::KEY_W-1:0]     key,
    input  logic [COUNT_WIDTH-1:0]        hits,
    input  logic [khc_pkg::RRANK_W-1:0]   read_rank,
    output khc_pkg::khc_tbl_stat_t        stat,
    output logic [khc_pkg::KEY_W-1:0]     entry_key,
    output logic [COUNT_WIDTH-1:0]        entry_hits,
    output logic                          entry_valid
);
    import khc_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);
    localparam logic [IW-1:0] LAST = IW'(TABLE_SIZE - 1);

    khc_tbl_state_t state_reg, state_next;

    logic [KEY_W-1:0]       keys_reg [TABLE_SIZE];
    logic [COUNT_WIDTH-1:0] hits_reg [TABLE_SIZE];

    logic [IW-1:0]          idx_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [COUNT_WIDTH-1:0] h_reg;
    logic                   apply_reg;
    logic                   found_reg;
    logic [IW-1:0]          r_reg;
    logic                   pfound_reg;
    logic [IW-1:0]          p_reg;
    logic [RANK_W-1:0]      rank_reg;
    logic                   done_reg;
    logic [KEY_W-1:0]       rd_key_reg;
    logic [COUNT_WIDTH-1:0] rd_hits_reg;
    logic                   rd_valid_reg;

    logic [IW-1:0]          rd_idx;
    logic [KEY_W-1:0]       cur_key;
    logic [COUNT_WIDTH-1:0] cur_hits;
    logic                   in_range;
    logic [IW-1:0]          pos;
    logic [IW-1:0]          end_idx;
    logic                   do_ins;
    logic [RANK_W-1:0]      new_rank;

    // single read port: read rank while idle, walk index otherwise
    assign rd_idx   = (state_reg == TBL_IDLE) ? IW'(read_rank) : idx_reg;
    assign cur_key  = keys_reg[rd_idx];
    assign cur_hits = hits_reg[rd_idx];
    assign in_range = (32'(read_rank) < 32'(TABLE_SIZE));

    always_comb
    begin
        // a present key moves to the first slot with fewer hits, never below itself
        if (found_reg)
        begin
            pos     = (pfound_reg && (p_reg < r_reg)) ? p_reg : r_reg;
            end_idx = r_reg;
        end
        else
        begin
            pos     = p_reg;
            end_idx = LAST;
        end
        do_ins = apply_reg && (found_reg || pfound_reg);
        if (do_ins)
            new_rank = RANK_W'(pos);
        else if (!apply_reg && found_reg)
            new_rank = RANK_W'(r_reg);
        else
            new_rank = RANK_W'(TABLE_SIZE);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            TBL_IDLE:
            begin
                if (ctrl.scan)
                    state_next = TBL_SCAN;
            end
            TBL_SCAN:
            begin
                if (idx_reg == LAST)
                    state_next = TBL_UPDATE;
            end
            TBL_UPDATE:
            begin
                state_next = TBL_IDLE;
            end
            default:
            begin
                state_next = TBL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= TBL_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < TABLE_SIZE; j++)
            begin
                keys_reg[j] <= '0;
                hits_reg[j] <= '0;
            end
            idx_reg      <= '0;
            key_reg      <= '0;
            h_reg        <= '0;
            apply_reg    <= 1'b0;
            found_reg    <= 1'b0;
            r_reg        <= '0;
            pfound_reg   <= 1'b0;
            p_reg        <= '0;
            rank_reg     <= '0;
            done_reg     <= 1'b0;
            rd_key_reg   <= '0;
            rd_hits_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                TBL_IDLE:
                begin
                    if (ctrl.scan)
                    begin
                        key_reg    <= key;
                        h_reg      <= hits;
                        apply_reg  <= ctrl.apply;
                        idx_reg    <= '0;
                        found_reg  <= 1'b0;
                        pfound_reg <= 1'b0;
                        r_reg      <= '0;
                        p_reg      <= '0;
                    end
                    else if (ctrl.read)
                    begin
                        if (in_range && (cur_hits != '0))
                        begin
                            rd_key_reg   <= cur_key;
                            rd_hits_reg  <= cur_hits;
                            rd_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            rd_key_reg   <= '0;
                            rd_hits_reg  <= '0;
                            rd_valid_reg <= 1'b0;
                        end
                        done_reg <= 1'b1;
                    end
                end
                TBL_SCAN:
                begin
                    if (!found_reg && (cur_hits != '0) && (cur_key == key_reg))
                    begin
                        found_reg <= 1'b1;
                        r_reg     <= idx_reg;
                    end
                    // empty slots hold zero hits, so they count as fewer
                    if (!pfound_reg && (cur_hits < h_reg))
                    begin
                        pfound_reg <= 1'b1;
                        p_reg      <= idx_reg;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                TBL_UPDATE:
                begin
                    if (do_ins)
                    begin
                        for (int j = 1; j < TABLE_SIZE; j++)
                        begin
                            if ((IW'(j) > pos) && (IW'(j) <= end_idx))
                            begin
                                keys_reg[j] <= keys_reg[j-1];
                                hits_reg[j] <= hits_reg[j-1];
                            end
                        end
                        keys_reg[pos] <= key_reg;
                        hits_reg[pos] <= h_reg;
                    end
                    rank_reg <= new_rank;
                    done_reg <= 1'b1;
                end
                default:
                begin
                    done_reg <= 1'b0;
                end
            endcase
        end
    end

    assign stat.done   = done_reg;
    assign stat.rank   = rank_reg;
    assign entry_key   = rd_key_reg;
    assign entry_hits  = rd_hits_reg;
    assign entry_valid = rd_valid_reg;

endmodule

FILE: tb/sv/key_hit_counter_top_ten_unit_test.sv
`timescale 1ns / 1ps

module key_hit_counter_top_ten_unit_test;
    import khc_pkg::*;

    localparam int TOP_N      = TABLE_SIZE_DEF;
    localparam int KEYS       = KEY_COUNT_DEF;
    localparam int HOT_KEYS   = 16;
    localparam int PHASES     = 9;
    localparam int PHASE_ITEMS = 178;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = TOP_N + 10;

    typedef enum logic { ROW_ITEM, ROW_CONFIG } row_op_t;

    typedef struct {
        row_op_t            op;
        khc_req_t           item;
        bit                 typed;
        khc_rsp_t           rsp;
        logic               skip;
        logic [SEL_W-1:0]   hsel;
    } plan_row_t;

    typedef struct {
        bit       typed;
        khc_rsp_t rsp;
    } typed_rsp_t;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    khc_req_t         req = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    khc_rsp_t         rsp;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic             cfg_index = CFG_SKIP_NON_WEB;
    logic [SEL_W-1:0] cfg_data = '0;

    // mirror of the block state
    logic [OCOUNT_W-1:0] hits_by_key [KEYS];
    logic [KEY_W-1:0]    top_keys [TOP_N];
    logic [OCOUNT_W-1:0] top_hits [TOP_N];
    logic                skip_non_web_cfg;
    logic [SEL_W-1:0]    hour_select_cfg;

    khc_rsp_t      expected_rsp_q [$];
    typed_rsp_t    typed_rsp_q [$];
    logic [KEY_W-1:0] hot_keys [HOT_KEYS];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int error_count = 0;
    int n_count_items = 0;
    int n_passed = 0;
    int n_reads = 0;
    int n_valid_reads = 0;
    int n_cfg_writes = 0;

    key_hit_counter_top_ten_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int rank_of(logic [KEY_W-1:0] k);
        for (int r = 0; r < TOP_N; r++)
            if (top_hits[r] != 0 && top_keys[r] == k)
                return r;
        return TOP_N;
    endfunction

    // promote a present key, or insert a new one ahead of the first smaller entry
    function automatic void offer_key(logic [KEY_W-1:0] k, logic [OCOUNT_W-1:0] h);
        int r;
        logic [KEY_W-1:0] tk;
        logic [OCOUNT_W-1:0] th;
        r = rank_of(k);
        if (r < TOP_N)
        begin
            top_hits[r] = h;
            while (r > 0 && top_hits[r-1] < top_hits[r])
            begin
                tk = top_keys[r-1];
                th = top_hits[r-1];
                top_keys[r-1] = top_keys[r];
                top_hits[r-1] = top_hits[r];
                top_keys[r] = tk;
                top_hits[r] = th;
                r--;
            end
            return;
        end
        for (int i = 0; i < TOP_N; i++)
        begin
            if (top_hits[i] == 0 || h > top_hits[i])
            begin
                for (int j = TOP_N - 1; j > i; j--)
                begin
                    top_keys[j] = top_keys[j-1];
                    top_hits[j] = top_hits[j-1];
                end
                top_keys[i] = k;
                top_hits[i] = h;
                return;
            end
        end
    endfunction

    function automatic khc_rsp_t predict_rsp(khc_req_t r);
        khc_rsp_t o;
        logic pass;
        o = '0;
        if (r.kind == KIND_COUNT)
        begin
            pass = !(skip_non_web_cfg && !r.is_web_content) &&
                   (hour_select_cfg == HOUR_ANY || hour_select_cfg == {1'b0, r.hour});
            if (pass)
            begin
                if (hits_by_key[r.key] != '1)
                    hits_by_key[r.key]++;
                offer_key(r.key, hits_by_key[r.key]);
            end
            o.accepted = pass;
            o.key_count = hits_by_key[r.key];
            o.key_rank = RRANK_W'(rank_of(r.key));
        end
        else if (r.read_rank < TOP_N && top_hits[r.read_rank] != 0)
        begin
            o.entry_key = top_keys[r.read_rank];
            o.entry_hits = top_hits[r.read_rank];
            o.entry_valid = 1'b1;
        end
        return o;
    endfunction

    task automatic note_failure(string what, khc_rsp_t want, khc_rsp_t got);
        error_count++;
        if (error_count <= 10)
        begin
            $display("%0t %s: want acc=%0b cnt=%0d rank=%0d ekey=%0d ehits=%0d ev=%0b",
                     $realtime, what, want.accepted, want.key_count, want.key_rank,
                     want.entry_key, want.entry_hits, want.entry_valid);
            $display("    got acc=%0b cnt=%0d rank=%0d ekey=%0d ehits=%0d ev=%0b",
                     got.accepted, got.key_count, got.key_rank,
                     got.entry_key, got.entry_hits, got.entry_valid);
        end
    endtask

    always @(posedge clk)
    begin
        khc_rsp_t want;
        typed_rsp_t typed;
        if (rst_n)
        begin
            if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            begin
                if (expected_rsp_q.size() == 0)
                    note_failure("result with nothing outstanding", '0, rsp);
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.accepted !== want.accepted || rsp.key_count !== want.key_count ||
                        rsp.key_rank !== want.key_rank || rsp.entry_key !== want.entry_key ||
                        rsp.entry_hits !== want.entry_hits ||
                        rsp.entry_valid !== want.entry_valid)
                        note_failure("result mismatch", want, rsp);
                end
            end
            if (req_valid && req_stall === 1'b0)
            begin
                typed = typed_rsp_q.pop_front();
                want = predict_rsp(req);
                if (req.kind == KIND_COUNT)
                begin
                    n_count_items++;
                    n_passed += want.accepted;
                end
                else
                begin
                    n_reads++;
                    n_valid_reads += want.entry_valid;
                end
                if (typed.typed)
                    want = typed.rsp;
                expected_rsp_q.push_back(want);
            end
            if (cfg_valid && cfg_ready === 1'b1)
            begin
                n_cfg_writes++;
                case (cfg_index)
                    CFG_SKIP_NON_WEB: skip_non_web_cfg = cfg_data[0];
                    CFG_HOUR_SELECT:  hour_select_cfg = cfg_data;
                endcase
            end
        end
    end

    // output back-pressure, with long hold-offs on request
    initial
    begin
        int hold_left;
        int holds_done;
        hold_left = 0;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_requests)
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_req(khc_req_t item, bit typed, khc_rsp_t rsp_typed);
        typed_rsp_t t;
        t.typed = typed;
        t.rsp = rsp_typed;
        typed_rsp_q.push_back(t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic apply_config(logic skip, logic [SEL_W-1:0] hsel);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SKIP_NON_WEB;
        cfg_data <= {{(SEL_W-1){1'b0}}, skip};
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_index <= CFG_HOUR_SELECT;
        cfg_data <= hsel;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic khc_req_t mk_count(int k, bit web, int hr);
        khc_req_t r;
        r = '0;
        r.kind = KIND_COUNT;
        r.key = KEY_W'(k);
        r.is_web_content = web;
        r.hour = HOUR_W'(hr);
        r.read_rank = RRANK_W'($urandom);
        return r;
    endfunction

    function automatic khc_req_t mk_read(int rank);
        khc_req_t r;
        r = '0;
        r.kind = KIND_READ;
        r.key = KEY_W'($urandom);
        r.is_web_content = 1'($urandom);
        r.hour = HOUR_W'($urandom);
        r.read_rank = RRANK_W'(rank);
        return r;
    endfunction

    function automatic khc_rsp_t count_rsp(bit acc, int cnt, int rank);
        khc_rsp_t o;
        o = '0;
        o.accepted = acc;
        o.key_count = OCOUNT_W'(cnt);
        o.key_rank = RRANK_W'(rank);
        return o;
    endfunction

    function automatic khc_rsp_t entry_rsp(int k, int h);
        khc_rsp_t o;
        o = '0;
        o.entry_key = KEY_W'(k);
        o.entry_hits = OCOUNT_W'(h);
        o.entry_valid = 1'b1;
        return o;
    endfunction

    function automatic plan_row_t fixed_row(khc_req_t item, khc_rsp_t want);
        plan_row_t p;
        p.op = ROW_ITEM;
        p.item = item;
        p.typed = 1'b1;
        p.rsp = want;
        p.skip = 1'b0;
        p.hsel = HOUR_ANY;
        return p;
    endfunction

    function automatic plan_row_t pred_row(khc_req_t item);
        plan_row_t p;
        p = fixed_row(item, '0);
        p.typed = 1'b0;
        return p;
    endfunction

    function automatic plan_row_t config_row(logic skip, logic [SEL_W-1:0] hsel);
        plan_row_t p;
        p = fixed_row('0, '0);
        p.op = ROW_CONFIG;
        p.skip = skip;
        p.hsel = hsel;
        return p;
    endfunction

    // rank reads and count events, mostly on hot keys that climb the table, with a spread of cold keys
    function automatic khc_req_t random_item();
        khc_req_t r;
        int k;
        int hr;
        if ($urandom_range(99) < 25)
            return mk_read($urandom_range(99) < 80 ? $urandom_range(TOP_N - 1)
                                                   : $urandom_range(15));
        k = ($urandom_range(99) < 60) ? hot_keys[$urandom_range(HOT_KEYS - 1)]
                                      : $urandom_range(KEYS - 1);
        hr = $urandom_range(31);
        if (!hour_select_cfg[SEL_W-1] && $urandom_range(99) < 70)
            hr = hour_select_cfg[HOUR_W-1:0];
        r = mk_count(k, $urandom_range(99) < 80, hr);
        return r;
    endfunction

    initial
    begin
        plan_row_t plan [$];
        logic phase_skip [PHASES];
        logic [SEL_W-1:0] phase_hour [PHASES];

        foreach (hits_by_key[i])
            hits_by_key[i] = '0;
        foreach (top_keys[i])
        begin
            top_keys[i] = '0;
            top_hits[i] = '0;
        end
        skip_non_web_cfg = 1'b0;
        hour_select_cfg = HOUR_ANY;

        phase_skip = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
        phase_hour = '{HOUR_ANY, 6'd0, 6'd23, HOUR_ANY, 6'd31, 6'h20, HOUR_ANY,
                       SEL_W'($urandom_range(63)), 6'd12};

        send_idle_pct = 36;
        recv_stall_pct = 45;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, an out-of-range rank, both key extremes and a tie
        plan.push_back(fixed_row(mk_read(0), '0));
        plan.push_back(fixed_row(mk_read(15), '0));
        plan.push_back(fixed_row(mk_read(9), '0));
        plan.push_back(fixed_row(mk_count(0, 1'b0, 0), count_rsp(1, 1, 0)));
        plan.push_back(fixed_row(mk_count(1023, 1'b1, 31), count_rsp(1, 1, 1)));
        plan.push_back(fixed_row(mk_count(1023, 1'b1, 23), count_rsp(1, 2, 0)));
        plan.push_back(fixed_row(mk_read(0), entry_rsp(1023, 2)));
        plan.push_back(fixed_row(mk_read(1), entry_rsp(0, 1)));
        plan.push_back(fixed_row(mk_read(2), '0));
        // non-web filtering; rejected events report the current count and rank
        plan.push_back(config_row(1'b1, HOUR_ANY));
        plan.push_back(fixed_row(mk_count(5, 1'b0, 3), count_rsp(0, 0, TOP_N)));
        plan.push_back(fixed_row(mk_count(0, 1'b0, 3), count_rsp(0, 1, 1)));
        plan.push_back(fixed_row(mk_count(5, 1'b1, 3), count_rsp(1, 1, 2)));
        plan.push_back(config_row(1'b1, 6'd23));
        plan.push_back(fixed_row(mk_count(7, 1'b1, 22), count_rsp(0, 0, TOP_N)));
        plan.push_back(fixed_row(mk_count(7, 1'b1, 23), count_rsp(1, 1, 3)));
        // hour select beyond the day matches only an equal hour field
        plan.push_back(config_row(1'b1, 6'd31));
        plan.push_back(fixed_row(mk_count(8, 1'b1, 31), count_rsp(1, 1, 4)));
        // negative select other than any never matches
        plan.push_back(config_row(1'b0, 6'h20));
        plan.push_back(fixed_row(mk_count(8, 1'b0, 0), count_rsp(0, 1, 4)));
        plan.push_back(config_row(1'b0, HOUR_ANY));
        for (int k = 9; k <= 13; k++)
            plan.push_back(pred_row(mk_count(k, 1'b0, k)));
        // full table: first hit stays out, second one pushes the last entry off
        plan.push_back(pred_row(mk_count(14, 1'b1, 1)));
        plan.push_back(pred_row(mk_count(14, 1'b1, 2)));
        plan.push_back(pred_row(mk_read(9)));
        plan.push_back(fixed_row(mk_read(10), '0));

        foreach (plan[i])
        begin
            if (plan[i].op == ROW_CONFIG)
            begin
                wait_drained();
                apply_config(plan[i].skip, plan[i].hsel);
            end
            else
                send_req(plan[i].item, plan[i].typed, plan[i].rsp);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p / 3)
                0:
                begin
                    send_idle_pct = 36;
                    recv_stall_pct = 45;
                end
                1:
                begin
                    send_idle_pct = 45;
                    recv_stall_pct = 36;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            foreach (hot_keys[i])
                hot_keys[i] = KEY_W'($urandom_range(KEYS - 1));
            apply_config(phase_skip[p], phase_hour[p]);
            if (p == 0 || p == 6)
                hold_requests++;
            repeat (PHASE_ITEMS)
                send_req(random_item(), 1'b0, '0);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d count events (%0d through the filter), %0d rank reads (%0d filled)",
                 n_count_items, n_passed, n_reads, n_valid_reads);
        $display("under %0d register writes, output hold-offs and three idle patterns",
                 n_cfg_writes);
        if (error_count == 0 && expected_rsp_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
design/khc_pkg.sv
design/khc_rank_table.sv
design/key_hit_counter_top_ten_unit.sv
tb/sv/key_hit_counter_top_ten_unit_test.sv
